/* src/cat_pkg.sv */
package cat_pkg;

    // Switch channel thresholds (pulse width)
    localparam logic [11:0] SW_HIGH = 12'd1700;
    localparam logic [11:0] SW_LOW  = 12'd1300;
    localparam logic [11:0] SW_TOP  = 12'd2200;

    // Camera status codes
    localparam logic [7:0] STATUS_CAM = 8'h60;
    localparam logic [7:0] STATUS_FC  = 8'h50;

    localparam logic [15:0] LOST_MAX   = 16'hFFFF;
    localparam logic [14:0] ARRIVE_MAX = 15'h7FFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAW_LIMIT    = 3'd0,
        CFG_USED_LIMIT   = 3'd1,
        CFG_MAX_STEP     = 3'd2,
        CFG_LOST_HOLD    = 3'd3,
        CFG_CENTER_THR   = 3'd4,
        CFG_POS_THR      = 3'd5,
        CFG_ARRIVE_TICKS = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ENTER  = 2'd1,
        EV_EXIT   = 2'd2,
        EV_ARRIVE = 2'd3
    } t_event;

    typedef struct packed {
        logic [11:0]        switch_value;
        logic [7:0]         cam_status;
        logic signed [15:0] cam_dx;
        logic signed [15:0] cam_dy;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic               fast_limit;
        logic               assist_active;
        t_event             event_res;
    } t_out_word;

    typedef struct packed {
        logic [9:0]  raw_offset_limit;
        logic [9:0]  used_offset_limit;
        logic [7:0]  max_target_step;
        logic [15:0] lost_hold_ticks;
        logic [7:0]  center_threshold;
        logic [7:0]  position_threshold;
        logic [14:0] arrive_ticks;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        raw_offset_limit:   10'd120,
        used_offset_limit:  10'd250,
        max_target_step:    8'd12,
        lost_hold_ticks:    16'd75,
        center_threshold:   8'd8,
        position_threshold: 8'd8,
        arrive_ticks:       15'd60
    };

    typedef struct packed {
        logic               assist_on;
        logic               sample_seen;
        logic [7:0]         last_status;
        logic [15:0]        last_dx;
        logic [15:0]        last_dy;
        logic [15:0]        lost_count;
        logic               filter_valid;
        logic signed [15:0] filter_x;
        logic signed [15:0] filter_y;
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [14:0]        arrive_count;
    } t_state;

    localparam t_state STATE_RST = '{
        assist_on:    1'b0,
        sample_seen:  1'b0,
        last_status:  8'h00,
        last_dx:      16'h0000,
        last_dy:      16'h0000,
        lost_count:   16'd76,
        filter_valid: 1'b0,
        filter_x:     16'sd0,
        filter_y:     16'sd0,
        goal_x:       16'sd0,
        goal_y:       16'sd0,
        arrive_count: 15'd0
    };

endpackage

/* src/cat_cfg.sv */
module cat_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cat_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cat_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output cat_pkg::t_cfg                    o_cfg
);
    import cat_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; unknown indexes drop the word
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAW_LIMIT:    n_cfg.raw_offset_limit   = i_cfg_data[9:0];
                CFG_USED_LIMIT:   n_cfg.used_offset_limit  = i_cfg_data[9:0];
                CFG_MAX_STEP:     n_cfg.max_target_step    = i_cfg_data[7:0];
                CFG_LOST_HOLD:    n_cfg.lost_hold_ticks    = i_cfg_data[15:0];
                CFG_CENTER_THR:   n_cfg.center_threshold   = i_cfg_data[7:0];
                CFG_POS_THR:      n_cfg.position_threshold = i_cfg_data[7:0];
                CFG_ARRIVE_TICKS: n_cfg.arrive_ticks       = i_cfg_data[14:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/cat_update.sv */
module cat_update (
    input  cat_pkg::t_in_word  i_word,
    input  cat_pkg::t_state    i_state,
    input  cat_pkg::t_cfg      i_cfg,
    output cat_pkg::t_state    o_state,
    output cat_pkg::t_out_word o_result
);
    import cat_pkg::*;

    function automatic logic [16:0] mag17(input logic signed [16:0] v);
        mag17 = v[16] ? 17'(-v) : 17'(v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v[16] != v[15]) begin
            sat16 = v[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    function automatic logic signed [11:0] clamp_off(input logic signed [15:0] v,
                                                      input logic [9:0] lim);
        logic signed [16:0] v17;
        logic signed [16:0] l17;
        v17 = 17'(v);
        l17 = 17'({7'd0, lim});
        if (v17 > l17) begin
            clamp_off = 12'(l17);
        end else if (v17 < -l17) begin
            clamp_off = 12'(-l17);
        end else begin
            clamp_off = 12'(v17);
        end
    endfunction

    // Quarter step toward the measurement, quotient truncated toward zero
    function automatic logic signed [15:0] filt(input logic signed [15:0] f,
                                                input logic signed [15:0] m);
        logic signed [16:0] d;
        logic signed [16:0] q;
        d = 17'(m) - 17'(f);
        q = (d + (d[16] ? 17'sd3 : 17'sd0)) >>> 2;
        filt = 16'(17'(f) + q);
    endfunction

    function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [7:0] step);
        logic signed [16:0] d;
        logic signed [16:0] s;
        d = 17'(tgt) - 17'(cur);
        s = 17'({9'd0, step});
        if (d > s) begin
            slew = 16'(17'(cur) + s);
        end else if (d < -s) begin
            slew = 16'(17'(cur) - s);
        end else begin
            slew = tgt;
        end
    endfunction

    t_state             e;
    t_state             n;
    logic               want;
    logic               changed;
    logic [15:0]        lost_rst;
    logic [15:0]        lost_inc;
    logic [14:0]        arr_inc;
    logic [7:0]         st;
    logic [15:0]        rdx;
    logic [15:0]        rdy;
    logic               fresh;
    logic               valid;
    logic               rok;
    logic               cok;
    logic               fast;
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [11:0]        cx_mag;
    logic [11:0]        cy_mag;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    t_event             ev;

    always_comb begin
        // Switch hysteresis
        want = i_state.assist_on;
        if (i_word.switch_value > SW_HIGH && i_word.switch_value < SW_TOP) begin
            want = 1'b1;
        end else if (i_word.switch_value < SW_LOW) begin
            want = 1'b0;
        end
        changed  = want != i_state.assist_on;
        lost_rst = (i_cfg.lost_hold_ticks == LOST_MAX) ? LOST_MAX
                                                        : i_cfg.lost_hold_ticks + 16'd1;

        // Entry or exit: restart tracking at the current position
        e   = i_state;
        st  = i_word.cam_status;
        rdx = i_word.cam_dx;
        rdy = i_word.cam_dy;
        ev  = EV_NONE;
        if (changed) begin
            e.assist_on    = want;
            e.last_status  = STATUS_FC;
            e.last_dx      = 16'd0;
            e.last_dy      = 16'd0;
            e.sample_seen  = 1'b1;
            e.lost_count   = lost_rst;
            e.filter_valid = 1'b0;
            e.goal_x       = i_word.pos_x;
            e.goal_y       = i_word.pos_y;
            e.filter_x     = i_word.pos_x;
            e.filter_y     = i_word.pos_y;
            e.arrive_count = 15'd0;
            st             = STATUS_FC;
            rdx            = 16'd0;
            rdy            = 16'd0;
            ev             = want ? EV_ENTER : EV_EXIT;
        end

        fresh = !e.sample_seen || st != e.last_status || rdx != e.last_dx
                || rdy != e.last_dy;
        valid = st == STATUS_CAM
                && mag17(17'(signed'(rdx))) <= {7'd0, i_cfg.raw_offset_limit}
                && mag17(17'(signed'(rdy))) <= {7'd0, i_cfg.raw_offset_limit};
        cx     = clamp_off(signed'(rdx), i_cfg.used_offset_limit);
        cy     = clamp_off(signed'(rdy), i_cfg.used_offset_limit);
        cx_mag = cx[11] ? 12'(-cx) : 12'(cx);
        cy_mag = cy[11] ? 12'(-cy) : 12'(cy);
        mx     = sat16(17'(i_word.pos_x) + 17'(cx));
        my     = sat16(17'(i_word.pos_y) + 17'(cy));
        lost_inc = (e.lost_count != LOST_MAX) ? e.lost_count + 16'd1 : e.lost_count;
        arr_inc  = (e.arrive_count != ARRIVE_MAX) ? e.arrive_count + 15'd1
                                                  : e.arrive_count;

        n    = e;
        fast = 1'b0;
        rok  = 1'b0;
        cok  = 1'b0;
        if (!e.assist_on) begin
            n.goal_x = i_word.pos_x;
            n.goal_y = i_word.pos_y;
        end else begin
            fast = 1'b1;
            if (fresh) begin
                n.sample_seen = 1'b1;
                n.last_status = st;
                n.last_dx     = rdx;
                n.last_dy     = rdy;
            end
            if (fresh && valid) begin
                n.lost_count   = 16'd0;
                n.filter_valid = 1'b1;
                n.filter_x     = e.filter_valid ? filt(e.filter_x, mx) : mx;
                n.filter_y     = e.filter_valid ? filt(e.filter_y, my) : my;
                n.goal_x       = slew(e.goal_x, n.filter_x, i_cfg.max_target_step);
                n.goal_y       = slew(e.goal_y, n.filter_y, i_cfg.max_target_step);
            end else begin
                n.lost_count = lost_inc;
                if (lost_inc > i_cfg.lost_hold_ticks) begin
                    n.filter_valid = 1'b0;
                    n.goal_x       = i_word.pos_x;
                    n.goal_y       = i_word.pos_y;
                    fast           = 1'b0;
                end
            end
            rok = mag17(17'(n.goal_x) - 17'(i_word.pos_x))
                      < {9'd0, i_cfg.position_threshold}
                  && mag17(17'(n.goal_y) - 17'(i_word.pos_y))
                      < {9'd0, i_cfg.position_threshold};
            cok = valid && cx_mag < {4'd0, i_cfg.center_threshold}
                  && cy_mag < {4'd0, i_cfg.center_threshold};
            n.arrive_count = (rok && cok) ? arr_inc : 15'd0;
            if (i_cfg.arrive_ticks != 15'd0 && n.arrive_count == i_cfg.arrive_ticks
                && ev == EV_NONE) begin
                ev = EV_ARRIVE;
            end
        end

        o_state                = n;
        o_result.target_x      = n.goal_x;
        o_result.target_y      = n.goal_y;
        o_result.fast_limit    = fast;
        o_result.assist_active = n.assist_on;
        o_result.event_res     = ev;
    end

endmodule

/* src/camera_assisted_target_tracker.sv */
// Camera-assisted target tracker. Each input word is one control tick (switch
// pulse width, camera status and offsets, current position); each tick yields
// exactly one result word (position target, speed-limit select, assist flag,
// event code). Throughput is one word per clock while results are taken: the
// whole tick update is a single pass of combinational logic between the input
// register and the result register. A word loads into the input register on
// accept and its result into the result register when it advances, which needs
// the result register free or being drained. While a finished result waits to
// be taken, the input still takes one more word into the input register and
// then holds ready low until the result is taken. The tracker state
// (hysteresis switch, last camera sample, lost and arrival counters, quarter-step
// filter and slewed goal) advances once per word as it moves into the result
// register. Configuration registers are written through i_cfg_we/i_cfg_idx/
// i_cfg_data; write them only while no word is in flight.
module camera_assisted_target_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  cat_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output cat_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_we,
    input  logic [cat_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cat_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cat_pkg::*;

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_word upd_result;

    logic      r_s1_valid;
    logic      n_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_word r_out_word;
    logic      in_accept;
    logic      adv;

    cat_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Tick update: pure logic from the held input word and current state
    cat_update u_update (
        .i_word   (r_s1_word),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (upd_result)
    );

    // Advance the held word whenever the result register is free or being drained
    assign adv        = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || adv;
    assign in_accept  = i_in_valid && o_in_ready;

    assign n_s1_valid  = in_accept || (r_s1_valid && !adv);
    assign n_out_valid = adv || (r_out_valid && !i_out_ready);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RST;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (adv) begin
                r_state <= n_state;
            end
        end
    end

    // Payload: capture input word on accept, result word on advance
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_word <= i_in_word;
        end
        if (adv) begin
            r_out_word <= upd_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef ASSERT_OFF
    a_fast_needs_assist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.fast_limit |-> o_out_word.assist_active)
        else $error("fast limit without assist");

    a_exit_clears_assist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_res == EV_EXIT |-> !o_out_word.assist_active)
        else $error("exit event with assist still active");

    a_enter_sets_assist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_res == EV_ENTER |-> o_out_word.assist_active)
        else $error("enter event without assist");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while pipeline full");

    a_state_moves_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_state))
        else $error("tracker state changed without a word advancing");
`endif

endmodule
